// ===== rtl/trm_pkg.sv =====
package trm_pkg;

  typedef struct packed {
    logic        [15:0] instruction_word;
    logic signed [15:0] following_word;
  } trm_in_t;

  typedef struct packed {
    logic [7:0]         next_line;
    logic               pixel_write;
    logic [2:0]         pixel_row;
    logic [2:0]         pixel_column;
    logic [15:0]        pixel_colour;
    logic               halted;
    logic signed [15:0] exit_code;
    logic [2:0]         status;
  } trm_out_t;

  localparam logic [4:0] OP_STORE   = 5'd0;
  localparam logic [4:0] OP_LOAD    = 5'd1;
  localparam logic [4:0] OP_PUTR    = 5'd2;
  localparam logic [4:0] OP_PUTM    = 5'd3;
  localparam logic [4:0] OP_COPYM   = 5'd4;
  localparam logic [4:0] OP_MOVE    = 5'd5;
  localparam logic [4:0] OP_SHL     = 5'd6;
  localparam logic [4:0] OP_SHR     = 5'd7;
  localparam logic [4:0] OP_ADD     = 5'd8;
  localparam logic [4:0] OP_SUB     = 5'd9;
  localparam logic [4:0] OP_MUL     = 5'd10;
  localparam logic [4:0] OP_DIV     = 5'd11;
  localparam logic [4:0] OP_AND     = 5'd12;
  localparam logic [4:0] OP_OR      = 5'd13;
  localparam logic [4:0] OP_NAND    = 5'd14;
  localparam logic [4:0] OP_NOR     = 5'd15;
  localparam logic [4:0] OP_PIX_RF  = 5'd16;
  localparam logic [4:0] OP_PIX_FR  = 5'd17;
  localparam logic [4:0] OP_JNZ     = 5'd18;
  localparam logic [4:0] OP_PUSH    = 5'd19;
  localparam logic [4:0] OP_POP     = 5'd20;
  localparam logic [4:0] OP_PIX_RR  = 5'd21;
  localparam logic [4:0] OP_PIX_FF  = 5'd22;
  localparam logic [4:0] OP_JZ      = 5'd23;
  localparam logic [4:0] OP_JMP     = 5'd24;
  localparam logic [4:0] OP_EXIT_A  = 5'd25;
  localparam logic [4:0] OP_EXIT_R  = 5'd26;

  localparam logic [2:0] ST_OK        = 3'd0;
  localparam logic [2:0] ST_BAD_OP    = 3'd1;
  localparam logic [2:0] ST_UNDERFLOW = 3'd2;
  localparam logic [2:0] ST_OVERFLOW  = 3'd3;
  localparam logic [2:0] ST_DIV_ZERO  = 3'd4;

endpackage

// ===== rtl/tiny_register_machine_core.sv =====
// Each accepted word is latched, then passes through the operand read, memory read
// and execute steps; a divide by a nonzero value also passes through the
// one-bit-a-cycle divider before execute. The data memory read port is registered.
// Only one instruction word is handled at a time: no new word is accepted until
// the waiting result has been taken. After reset a clearing pass zeroes all 256
// data memory words before the first word is accepted.
module tiny_register_machine_core
  import trm_pkg::*;
#(
  parameter int STACK_DEPTH = 64
) (
  input  logic     clk,
  input  logic     rst,
  input  logic     in_valid,
  output logic     in_stall,
  input  trm_in_t  in_data,
  output logic     out_valid,
  input  logic     out_stall,
  output trm_out_t out_data
);

  localparam int SW = (STACK_DEPTH > 1) ? $clog2(STACK_DEPTH) : 1;
  localparam int CW = $clog2(STACK_DEPTH + 1);

  typedef enum logic [6:0] {
    S_CLEAR = 7'b0000001,
    S_IDLE  = 7'b0000010,
    S_READ  = 7'b0000100,
    S_MEM   = 7'b0001000,
    S_DIV   = 7'b0010000,
    S_EXEC  = 7'b0100000,
    S_OUT   = 7'b1000000
  } state_t;

  state_t state;

  logic [15:0] regs [8];
  logic [15:0] dmem [256];
  logic [15:0] stk  [STACK_DEPTH];
  logic [CW-1:0] sp;
  logic [7:0]  pline;
  logic        stopped;
  logic [7:0]  clr_addr;

  logic [15:0] iw, imm, vd, v1, v2, mrd, srd;
  logic [7:0]  maddr;
  logic [4:0]  op;
  logic [2:0]  rd, rs1, rs2;
  trm_out_t    res;

  // Divider registers: restoring division on magnitudes.
  logic [15:0] dq, dr, dv;
  logic [4:0]  dcnt;
  logic        dneg;

  assign op  = iw[15:11];
  assign rd  = iw[10:8];
  assign rs1 = iw[6:4];
  assign rs2 = iw[2:0];

  assign in_stall  = (state != S_IDLE);
  assign out_valid = (state == S_OUT);
  assign out_data  = res;

  logic [16:0] dtrial;
  assign dtrial = {dr[15:0], dq[15]} - {1'b0, dv};

  // Shifter and arithmetic results for the register writing operations.
  logic [15:0] alu;
  logic [15:0] prod;
  assign prod = 16'(v1 * v2);
  always_comb begin
    alu = v2;
    case (op)
      OP_SHL:  alu = (v2 >= 16'd16) ? 16'd0 : 16'(v1 << v2[3:0]);
      OP_SHR:  alu = 16'($signed(v1) >>> ((v2 > 16'd15) ? 4'd15 : v2[3:0]));
      OP_ADD:  alu = 16'(v1 + v2);
      OP_SUB:  alu = 16'(v1 - v2);
      OP_MUL:  alu = prod;
      OP_DIV:  alu = dneg ? 16'(-dq) : dq;
      OP_AND:  alu = v1 & v2;
      OP_OR:   alu = v1 | v2;
      OP_NAND: alu = ~(v1 & v2);
      OP_NOR:  alu = ~(v1 | v2);
      OP_LOAD: alu = mrd;
      OP_PUTR: alu = imm;
      OP_POP:  alu = srd;
      default: alu = v2;
    endcase
  end

  // Sequencer with execute step.
  always_ff @(posedge clk) begin
    if (rst) begin
      state    <= S_CLEAR;
      clr_addr <= 8'd0;
      sp       <= '0;
      pline    <= 8'd0;
      stopped  <= 1'b0;
      for (int i = 0; i < 8; i++) regs[i] <= 16'd0;
    end else begin
      case (state)
        S_CLEAR: begin
          clr_addr <= clr_addr + 8'd1;
          if (clr_addr == 8'hff) state <= S_IDLE;
        end
        S_IDLE: begin
          if (in_valid) begin
            iw    <= in_data.instruction_word;
            imm   <= in_data.following_word;
            state <= S_READ;
          end
        end
        S_READ: begin
          vd    <= regs[rd];
          v1    <= regs[rs1];
          v2    <= regs[rs2];
          maddr <= (op == OP_COPYM) ? regs[rd][7:0] : iw[7:0];
          state <= S_MEM;
        end
        S_MEM: begin
          dq    <= v1[15] ? 16'(-v1) : v1;
          dv    <= v2[15] ? 16'(-v2) : v2;
          dr    <= 16'd0;
          dcnt  <= 5'd16;
          dneg  <= v1[15] ^ v2[15];
          state <= (op == OP_DIV && v2 != 16'd0 && !stopped) ? S_DIV : S_EXEC;
        end
        S_DIV: begin
          if (!dtrial[16]) begin
            dr <= dtrial[15:0];
            dq <= {dq[14:0], 1'b1};
          end else begin
            dr <= {dr[14:0], dq[15]};
            dq <= {dq[14:0], 1'b0};
          end
          dcnt <= dcnt - 5'd1;
          if (dcnt == 5'd1) state <= S_EXEC;
        end
        S_EXEC: begin
          trm_out_t   r;
          logic [7:0] nx;
          logic [2:0] st;
          r           = '0;
          r.next_line = pline;
          r.halted    = 1'b1;
          if (!stopped) begin
            nx = 8'(pline + 8'd1);
            st = ST_OK;
            case (op)
              OP_STORE, OP_COPYM, OP_PUTM: ;
              OP_LOAD, OP_MOVE, OP_SHL, OP_SHR, OP_ADD, OP_SUB, OP_MUL,
              OP_AND, OP_OR, OP_NAND, OP_NOR: regs[rd] <= alu;
              OP_PUTR: begin regs[rd] <= alu; nx = 8'(pline + 8'd2); end
              OP_DIV: begin
                if (v2 == 16'd0) st = ST_DIV_ZERO;
                else regs[rd] <= alu;
              end
              OP_PIX_RF, OP_PIX_FR, OP_PIX_RR, OP_PIX_FF: begin
                r.pixel_write  = 1'b1;
                r.pixel_colour = vd;
                r.pixel_row    = (op == OP_PIX_RF || op == OP_PIX_RR) ? v1[2:0] : rs1;
                r.pixel_column = (op == OP_PIX_FR || op == OP_PIX_RR) ? v2[2:0] : rs2;
              end
              OP_JNZ:  if (vd != 16'd0) nx = iw[7:0];
              OP_JZ:   if (vd == 16'd0) nx = iw[7:0];
              OP_JMP:  nx = iw[7:0];
              OP_PUSH: begin
                if (sp >= CW'(STACK_DEPTH)) st = ST_OVERFLOW;
                else sp <= sp + CW'(1);
              end
              OP_POP: begin
                if (sp == '0) st = ST_UNDERFLOW;
                else begin regs[rd] <= alu; sp <= sp - CW'(1); end
              end
              OP_EXIT_A: begin
                r.exit_code = {8'd0, iw[7:0]};
                nx = pline;
                stopped <= 1'b1;
              end
              OP_EXIT_R: begin
                r.exit_code = vd;
                nx = pline;
                stopped <= 1'b1;
              end
              default: st = ST_BAD_OP;
            endcase
            if (op == OP_PUTM) nx = 8'(pline + 8'd2);
            if (st != ST_OK) begin
              nx = pline;
              stopped <= 1'b1;
            end
            r.halted    = stopped | (st != ST_OK) | (op == OP_EXIT_A) | (op == OP_EXIT_R);
            r.status    = st;
            r.next_line = nx;
            pline      <= nx;
          end
          res   <= r;
          state <= S_OUT;
        end
        S_OUT: if (!out_stall) state <= S_IDLE;
        default: state <= S_IDLE;
      endcase
    end
  end

  // Data memory: clearing pass after reset, writes at execute, registered read.
  always_ff @(posedge clk) begin
    if (state == S_CLEAR) begin
      dmem[clr_addr] <= 16'd0;
    end else if (state == S_EXEC && !stopped) begin
      if (op == OP_STORE) dmem[iw[7:0]] <= vd;
      else if (op == OP_PUTM) dmem[iw[7:0]] <= imm;
      else if (op == OP_COPYM) dmem[iw[7:0]] <= mrd;
    end
    if (state == S_MEM) mrd <= dmem[maddr];
  end

  // Stack store: one write and one registered read.
  always_ff @(posedge clk) begin
    if (state == S_EXEC && !stopped && op == OP_PUSH && sp < CW'(STACK_DEPTH))
      stk[sp[SW-1:0]] <= vd;
    if (state == S_MEM) srd <= stk[SW'(sp - CW'(1))];
  end

  // Checks on the sequencer.
  a_stall_busy: assert property (@(posedge clk) disable iff (rst)
    (state != S_IDLE) |-> in_stall) else $error("accepting while busy");
  a_out_hold: assert property (@(posedge clk) disable iff (rst)
    (out_valid && out_stall) |=> out_valid) else $error("result dropped");
  a_sp_bound: assert property (@(posedge clk) disable iff (rst)
    sp <= CW'(STACK_DEPTH)) else $error("stack count beyond depth");
  a_stop_sticky: assert property (@(posedge clk) disable iff (rst)
    stopped |=> stopped) else $error("halt cleared");

endmodule
